/* sv/sbpe_pkg.sv */
// Shared types and constants for the sparse block pattern expander.
// Used by sbpe_ctrl, sbpe_dp and sparse_block_pattern_expand.
`timescale 1ns / 1ps
`default_nettype none

package sbpe_pkg;

  localparam int ACT_W      = 2;
  localparam int VAL_W      = 24;
  localparam int SLOT_W     = 30;
  localparam int DATA_W     = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_BLOCK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_BLOCK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_IN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_OUT = 2'd3;

  localparam logic KIND_PTR = 1'b0;
  localparam logic KIND_COL = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_ROW = 2'd0,
    ACT_COL = 2'd1,
    ACT_FIN = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SETUP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic setup;
    logic fire;
  } ctrl_cmd_t;

  typedef struct packed {
    logic act_known;
    logic last_beat;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* sv/sbpe_ctrl.sv */
// Controller state machine for the sparse block pattern expander.
// Depends on sbpe_pkg; drives commands into sbpe_dp and reads its status.
`timescale 1ns / 1ps
`default_nettype none

module sbpe_ctrl
  import sbpe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && stat.act_known) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_SETUP;
      end
      ST_SETUP: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free && stat.last_beat) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    cmd.load  = 1'b0;
    cmd.mul   = 1'b0;
    cmd.setup = 1'b0;
    cmd.fire  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid && stat.act_known;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      ST_EMIT: begin
        cmd.fire = stat.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/sbpe_dp.sv */
// Datapath of the sparse block pattern expander: configuration, row state,
// products, running slot and data counters, and the result register.
// Depends on sbpe_pkg; controlled by sbpe_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module sbpe_dp
  import sbpe_pkg::*;
#(
  parameter int MAX_BLOCK  = 8,
  parameter int INDEX_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ctrl_cmd_t             cmd,
  output dp_stat_t                   stat,
  input  wire logic [ACT_W-1:0]      action,
  input  wire logic [VAL_W-1:0]      first_value,
  input  wire logic [VAL_W-1:0]      second_value,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       kind,
  output logic [SLOT_W-1:0]          slot,
  output logic [DATA_W-1:0]          data,
  output logic                       last
);

  localparam int BW = $clog2(MAX_BLOCK + 1);
  localparam int KW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int IW = INDEX_BITS;

  logic [BW-1:0]     rb_c;
  logic [BW-1:0]     cb_c;
  logic              off_in;
  logic              off_out;
  logic [BW-1:0]     blk_next;

  action_t           act_r;
  logic [VAL_W-1:0]  first_r;
  logic [IW-1:0]     s_r;
  logic [IW-1:0]     len_r;
  logic [2*BW-1:0]   bs_r;

  logic [IW-1:0]     row_number;
  logic [IW-1:0]     row_start;
  logic [IW-1:0]     row_length;
  logic [IW-1:0]     row_position;

  logic [DATA_W-1:0] m1;
  logic [DATA_W-1:0] m2;
  logic [DATA_W-1:0] m3;
  logic [DATA_W-1:0] m4;
  logic [DATA_W-1:0] a1;
  logic [DATA_W-1:0] a2;
  logic [DATA_W-1:0] a3;
  logic [DATA_W-1:0] b3;
  logic [DATA_W-1:0] sum13;
  logic [DATA_W-1:0] dbase_next;

  logic [SLOT_W-1:0] slot_cur;
  logic [SLOT_W-1:0] row_acc;
  logic [SLOT_W-1:0] row_acc_next;
  logic [DATA_W-1:0] data_cur;
  logic [DATA_W-1:0] data_base;
  logic [KW-1:0]     k_cnt;
  logic [KW-1:0]     j_cnt;
  logic              k_last;
  logic              j_last;
  logic              last_beat;

  // Clamp a block size write into 1..MAX_BLOCK.
  always_comb begin
    if (cfg_data == '0) begin
      blk_next = BW'(1);
    end else if (cfg_data > CFG_DATA_W'(MAX_BLOCK)) begin
      blk_next = BW'(MAX_BLOCK);
    end else begin
      blk_next = BW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rb_c    <= BW'(1);
      cb_c    <= BW'(1);
      off_in  <= 1'b0;
      off_out <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_BLOCK:  rb_c    <= blk_next;
        REG_COL_BLOCK:  cb_c    <= blk_next;
        REG_OFFSET_IN:  off_in  <= cfg_data[0];
        REG_OFFSET_OUT: off_out <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Capture the beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= action_t'(action);
      first_r <= first_value;
      s_r     <= IW'(first_value) - IW'(off_in);
      len_r   <= IW'(second_value) - IW'(first_value);
      bs_r    <= (2 * BW)'(rb_c) * (2 * BW)'(cb_c);
    end
  end

  // Operand selection for the product stage.
  always_comb begin
    a1 = DATA_W'(first_r);
    a2 = DATA_W'(row_length);
    a3 = DATA_W'(row_number);
    b3 = DATA_W'(rb_c);
    unique case (act_r)
      ACT_ROW: begin
        a1 = DATA_W'(s_r);
        a2 = DATA_W'(len_r);
      end
      ACT_COL: begin
        a1 = DATA_W'(row_start);
        a3 = DATA_W'(row_position);
        b3 = DATA_W'(cb_c);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      m1 <= a1 * DATA_W'(bs_r);
      m2 <= a2 * DATA_W'(cb_c);
      m3 <= a3 * b3;
      m4 <= DATA_W'(s_r) * DATA_W'(cb_c);
    end
  end

  assign sum13        = m1 + m3;
  assign dbase_next   = m4 + DATA_W'(off_out);
  assign row_acc_next = row_acc + SLOT_W'(m2);

  assign k_last = (BW'(k_cnt) + BW'(1)) == rb_c;
  assign j_last = (BW'(j_cnt) + BW'(1)) == cb_c;

  always_comb begin
    unique case (act_r)
      ACT_ROW: last_beat = k_last;
      ACT_COL: last_beat = k_last && j_last;
      default: last_beat = 1'b1;
    endcase
  end

  // Row state.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_number   <= '0;
      row_start    <= '0;
      row_length   <= '0;
      row_position <= '0;
    end else if (cmd.setup) begin
      unique case (act_r)
        ACT_ROW: begin
          row_start    <= s_r;
          row_length   <= len_r;
          row_position <= '0;
          row_number   <= row_number + IW'(1);
        end
        ACT_COL: begin
          row_position <= row_position + IW'(1);
        end
        default: begin
          row_number   <= '0;
          row_start    <= '0;
          row_length   <= '0;
          row_position <= '0;
        end
      endcase
    end
  end

  // Running slot and data for the beats of one item.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      k_cnt <= '0;
      j_cnt <= '0;
      unique case (act_r)
        ACT_COL: begin
          row_acc   <= SLOT_W'(sum13);
          slot_cur  <= SLOT_W'(sum13);
          data_base <= dbase_next;
          data_cur  <= dbase_next;
        end
        default: begin
          slot_cur <= SLOT_W'(m3);
          data_cur <= m1 + DATA_W'(off_out);
        end
      endcase
    end else if (cmd.fire) begin
      unique case (act_r)
        ACT_ROW: begin
          k_cnt    <= k_cnt + KW'(1);
          slot_cur <= slot_cur + SLOT_W'(1);
          data_cur <= data_cur + m2;
        end
        ACT_COL: begin
          if (j_last) begin
            j_cnt    <= '0;
            k_cnt    <= k_cnt + KW'(1);
            row_acc  <= row_acc_next;
            slot_cur <= row_acc_next;
            data_cur <= data_base;
          end else begin
            j_cnt    <= j_cnt + KW'(1);
            slot_cur <= slot_cur + SLOT_W'(1);
            data_cur <= data_cur + DATA_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      kind <= (act_r == ACT_COL) ? KIND_COL : KIND_PTR;
      slot <= slot_cur;
      data <= data_cur;
      last <= last_beat;
    end
  end

  assign stat.act_known = (action == ACT_ROW) || (action == ACT_COL) || (action == ACT_FIN);
  assign stat.last_beat = last_beat;
  assign stat.out_free  = !out_valid || !out_stall;

endmodule

`default_nettype wire

/* sv/sparse_block_pattern_expand.sv */
// Top level of the sparse block pattern expander.
// Depends on sbpe_pkg, sbpe_ctrl and sbpe_dp.
//
//   channel  handshake                  payload
//   -------  -------------------------  -------------------------------------
//   in       in_valid / in_stall        action, first_value, second_value
//   out      out_valid / out_stall      kind, slot, data, last
//   cfg      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// An unknown action is dropped in its accept cycle. The single result register
// emits one beat per cycle unless out_stall holds it.
// rst is synchronous and clears config to its defaults and row state to zero.
// out_stall holds the result register and pauses emission; in_stall is low
// only while no item is in work.
`timescale 1ns / 1ps
`default_nettype none

module sparse_block_pattern_expand
  import sbpe_pkg::*;
#(
  parameter int MAX_BLOCK  = 8,
  parameter int INDEX_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [ACT_W-1:0]      action,
  input  wire logic [VAL_W-1:0]      first_value,
  input  wire logic [VAL_W-1:0]      second_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       kind,
  output logic [SLOT_W-1:0]          slot,
  output logic [DATA_W-1:0]          data,
  output logic                       last,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  sbpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sbpe_dp #(
    .MAX_BLOCK  (MAX_BLOCK),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .action       (action),
    .first_value  (first_value),
    .second_value (second_value),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .slot         (slot),
    .data         (data),
    .last         (last)
  );

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking bench for sparse_block_pattern_expand: expands block rows into
// predicted result beats and checks every beat the block emits.
// Depends on sbpe_pkg and the sparse_block_pattern_expand RTL.
`timescale 1ns / 1ps

module testbench;
  import sbpe_pkg::*;

  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
  localparam int BLOCK_MAX = 8;
  localparam int HOLD_CYCLES = 400;

  class pattern_expander;
    typedef struct packed {
      logic              kind;
      logic [SLOT_W-1:0] slot;
      logic [DATA_W-1:0] data;
      logic              last;
    } beat_t;

    beat_t             expanded_beats[$];
    logic [3:0]        row_block_reg;
    logic [3:0]        col_block_reg;
    logic              offset_in_reg;
    logic              offset_out_reg;
    logic [VAL_W-1:0]  row_number;
    logic [VAL_W-1:0]  row_start;
    logic [VAL_W-1:0]  row_length;
    logic [VAL_W-1:0]  row_position;
    int unsigned       mismatches;
    int unsigned       beats_matched;

    function new();
      row_block_reg  = 4'd1;
      col_block_reg  = 4'd1;
      offset_in_reg  = 1'b0;
      offset_out_reg = 1'b0;
      row_number     = '0;
      row_start      = '0;
      row_length     = '0;
      row_position   = '0;
      mismatches     = 0;
      beats_matched  = 0;
    endfunction

    function void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ROW_BLOCK:  row_block_reg = val;
        REG_COL_BLOCK:  col_block_reg = val;
        REG_OFFSET_IN:  offset_in_reg = val[0];
        REG_OFFSET_OUT: offset_out_reg = val[0];
        default: ;
      endcase
    endfunction

    function longint unsigned block_dim(logic [3:0] v);
      if (v == 4'd0) return 64'd1;
      if (v > 4'(BLOCK_MAX)) return 64'(BLOCK_MAX);
      return 64'(v);
    endfunction

    function void push_beat(logic k, longint unsigned slot_v, longint unsigned data_v,
                            logic last_v);
      beat_t b;
      b.kind = k;
      b.slot = slot_v[SLOT_W-1:0];
      b.data = data_v[DATA_W-1:0];
      b.last = last_v;
      expanded_beats.push_back(b);
    endfunction

    function void expand_item(logic [ACT_W-1:0] act, logic [VAL_W-1:0] first,
                              logic [VAL_W-1:0] second);
      longint unsigned rb, cb, bs, s, len, c, k, j;
      logic [VAL_W-1:0] diff;
      rb = block_dim(row_block_reg);
      cb = block_dim(col_block_reg);
      bs = rb * cb;
      case (act)
        ACT_ROW: begin
          diff = first - VAL_W'(offset_in_reg);
          s = 64'(diff);
          diff = second - first;
          len = 64'(diff);
          for (k = 0; k < rb; k++) begin
            push_beat(KIND_PTR, longint'(row_number) * rb + k,
                      s * bs + len * cb * k + 64'(offset_out_reg), k + 1 == rb);
          end
          row_start    = s[VAL_W-1:0];
          row_length   = len[VAL_W-1:0];
          row_position = '0;
          row_number   = row_number + VAL_W'(1);
        end
        ACT_COL: begin
          diff = first - VAL_W'(offset_in_reg);
          c = 64'(diff);
          for (k = 0; k < rb; k++) begin
            for (j = 0; j < cb; j++) begin
              push_beat(KIND_COL,
                        longint'(row_start) * bs + longint'(row_length) * cb * k
                          + longint'(row_position) * cb + j,
                        c * cb + j + 64'(offset_out_reg), k + 1 == rb && j + 1 == cb);
            end
          end
          row_position = row_position + VAL_W'(1);
        end
        ACT_FIN: begin
          push_beat(KIND_PTR, longint'(row_number) * rb,
                    longint'(first) * bs + 64'(offset_out_reg), 1'b1);
          row_number   = '0;
          row_start    = '0;
          row_length   = '0;
          row_position = '0;
        end
        default: ;
      endcase
    endfunction

    function void check_beat(logic k, logic [SLOT_W-1:0] s, logic [DATA_W-1:0] d,
                             logic l);
      beat_t want;
      if (expanded_beats.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat kind %0h slot %0h data %0h last %0h",
                 $time, k, s, d, l);
        return;
      end
      want = expanded_beats.pop_front();
      if (want.kind !== k || want.slot !== s || want.data !== d || want.last !== l) begin
        mismatches++;
        $display(
          "%0t: beat mismatch kind/slot/data/last expected %0h/%0h/%0h/%0h got %0h/%0h/%0h/%0h",
          $time, want.kind, want.slot, want.data, want.last, k, s, d, l);
      end else begin
        beats_matched++;
      end
    endfunction
  endclass

  bit                    clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [ACT_W-1:0]      action;
  logic [VAL_W-1:0]      first_value;
  logic [VAL_W-1:0]      second_value;
  logic                  out_valid;
  logic                  out_stall;
  logic                  kind;
  logic [SLOT_W-1:0]     slot;
  logic [DATA_W-1:0]     data;
  logic                  last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pattern_expander expander = new();
  bit  idling_on = 1'b1;
  bit  long_hold_req = 1'b0;
  bit  hold_taken = 1'b0;
  int  hold_left = 0;
  int  n_items = 0;
  int  n_settings = 0;

  sparse_block_pattern_expand i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .first_value(first_value), .second_value(second_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .slot(slot), .data(data), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("%0t: run timed out", $time);
    $display("FAILURE");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idling_on && $urandom_range(99) < 19;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      expander.check_beat(kind, slot, data, last);
    end
  end

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] f,
                           input logic [VAL_W-1:0] s);
    while (idling_on && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    first_value  <= f;
    second_value <= s;
    do @(posedge clk); while (in_stall);
    expander.expand_item(act, f, s);
    if (act != ACT_NONE) n_items++;
    @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    expander.store_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic load_config(input logic [3:0] rb, input logic [3:0] cb,
                             input logic [3:0] oin, input logic [3:0] oout);
    set_reg(REG_ROW_BLOCK, rb);
    set_reg(REG_COL_BLOCK, cb);
    set_reg(REG_OFFSET_IN, oin);
    set_reg(REG_OFFSET_OUT, oout);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // hold the input side until every predicted beat has arrived
  task automatic drain();
    in_valid <= 1'b0;
    while (expander.expanded_beats.size() != 0) @(negedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (16) @(negedge clk);
  endtask

  function automatic logic [3:0] pick_dim();
    case ($urandom_range(9))
      0: return 4'd0;
      1: return 4'($urandom_range(9, 15));
      2: return 4'd8;
      3: return 4'd1;
      default: return 4'($urandom_range(2, 4));
    endcase
  endfunction

  task automatic run_phase(input int quota);
    int               target, rows, len, entries, r, e;
    logic [VAL_W-1:0] base, ptr, col;
    logic             one_based;
    target = n_items + quota;
    one_based = expander.offset_in_reg;
    while (n_items < target) begin
      if ($urandom_range(9) == 0) begin
        send_item(ACT_W'($urandom_range(3)), VAL_W'($urandom), VAL_W'($urandom));
      end else begin
        base = ($urandom_range(3) == 0) ? VAL_W'($urandom)
                                        : VAL_W'($urandom_range(20)) + VAL_W'(one_based);
        ptr = base;
        rows = $urandom_range(1, 4);
        for (r = 0; r < rows; r++) begin
          len = $urandom_range(4);
          entries = len;
          if ($urandom_range(15) == 0) entries = len + 1;
          else if ($urandom_range(15) == 0 && len > 0) entries = len - 1;
          send_item(ACT_ROW, ptr, ptr + VAL_W'(len));
          for (e = 0; e < entries; e++) begin
            col = $urandom_range(1) ? VAL_W'($urandom)
                                    : VAL_W'($urandom_range(31)) + VAL_W'(one_based);
            send_item(ACT_COL, col, VAL_W'($urandom));
          end
          ptr = ptr + VAL_W'(len);
        end
        if ($urandom_range(15) != 0) begin
          send_item(ACT_FIN, ptr - VAL_W'(one_based), VAL_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    int p;
    rst          = 1'b1;
    in_valid     = 1'b0;
    action       = ACT_ROW;
    first_value  = '0;
    second_value = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_ROW_BLOCK;
    cfg_data     = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // reset settings: entry with no header, ignored action, full-scale values
    send_item(ACT_COL, 24'd5, 24'd0);
    send_item(ACT_NONE, 24'hFFFFFF, 24'hFFFFFF);
    send_item(ACT_ROW, 24'd0, 24'hFFFFFF);
    send_item(ACT_COL, 24'hFFFFFF, 24'd0);
    send_item(ACT_COL, 24'd0, 24'hFFFFFF);
    send_item(ACT_FIN, 24'hFFFFFF, 24'd0);
    settle();

    // largest blocks, one-based: start, end and column underflow
    load_config(4'd8, 4'd8, 4'd1, 4'd1);
    send_item(ACT_ROW, 24'd0, 24'd0);
    send_item(ACT_COL, 24'd0, 24'd0);
    send_item(ACT_ROW, 24'd10, 24'd5);
    send_item(ACT_COL, 24'hFFFFFF, 24'd0);
    send_item(ACT_NONE, 24'd0, 24'd0);
    send_item(ACT_FIN, 24'd0, 24'd0);
    settle();

    // out-of-range block sizes clamp; entries past the row length
    load_config(4'd0, 4'd15, 4'd0, 4'd1);
    send_item(ACT_ROW, 24'hFFFFFF, 24'd0);
    send_item(ACT_COL, 24'd3, 24'hFFFFFF);
    send_item(ACT_ROW, 24'd4, 24'd5);
    send_item(ACT_COL, 24'd1, 24'd0);
    send_item(ACT_COL, 24'd2, 24'd0);
    send_item(ACT_COL, 24'd9, 24'd0);
    send_item(ACT_FIN, 24'hFFFFFF, 24'hFFFFFF);
    settle();

    load_config(4'd15, 4'd0, 4'd3, 4'd2);
    send_item(ACT_ROW, 24'd1, 24'd3);
    send_item(ACT_COL, 24'd1, 24'd0);
    send_item(ACT_COL, 24'h800000, 24'd0);
    send_item(ACT_FIN, 24'd2, 24'd0);
    settle();

    for (p = 0; p < 8; p++) begin
      load_config(pick_dim(), pick_dim(), 4'($urandom_range(15)), 4'($urandom_range(15)));
      idling_on = (p != 3);
      if (p == 2) begin
        run_phase(30);
        drain();
        run_phase(32);
      end else if (p == 5) begin
        run_phase(10);
        long_hold_req = 1'b1;
        run_phase(52);
      end else begin
        run_phase(62);
      end
      settle();
    end
    idling_on = 1'b1;

    drain();
    repeat (80) @(negedge clk);
    $display("Expanded %0d source items into %0d checked beats over %0d register settings.",
             n_items, expander.beats_matched, n_settings);
    if (expander.expanded_beats.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time,
               expander.expanded_beats.size());
    end
    if (expander.mismatches == 0 && expander.expanded_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sbpe_pkg.sv
sv/sbpe_ctrl.sv
sv/sbpe_dp.sv
sv/sparse_block_pattern_expand.sv
dv/testbench.sv
